// File: src/hte_pkg.sv
package hte_pkg;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 63;
    localparam int LEN_W    = 6;
    localparam int SYM_NUM  = 256;
    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);
    localparam int QCW      = $clog2(QDEPTH + 1);

    localparam logic [SYM_W-1:0] SKIP_BYTE = 8'd8;
    localparam logic [LEN_W-1:0] LEN_MAX   = 6'd63;

    typedef enum logic [1:0] {
        K_STORE,
        K_DROP,
        K_SKIP
    } t_kind;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        t_kind            kind;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_length;
        logic              overflowed;
        logic              end_of_run;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LD,
        ST_LM,
        ST_LC,
        ST_LEND,
        ST_RK0,
        ST_RK1,
        ST_RS,
        ST_RW,
        ST_MG0,
        ST_MS,
        ST_MW1,
        ST_MW2,
        ST_WK0,
        ST_WK1,
        ST_WK2,
        ST_E0,
        ST_E1,
        ST_E2,
        ST_E3
    } t_state;

endpackage

// File: src/hte_front.sv
module hte_front #(
    parameter int MAX_TEXT = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [hte_pkg::SYM_W-1:0]   i_symbol,
    input  logic                        i_last,
    input  logic                        i_qfull,
    output logic                        o_full,
    output logic                        o_qpush,
    output hte_pkg::t_item              o_qitem
);

    localparam int CW = $clog2(MAX_TEXT + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          acc;
    logic          skip;
    logic          fits;

    assign acc     = i_push && !i_qfull;
    assign skip    = (i_symbol == hte_pkg::SKIP_BYTE);
    assign fits    = (r_cnt < CW'(MAX_TEXT));
    assign o_full  = i_qfull;
    // A skipped byte only matters to the back end when it closes the text.
    assign o_qpush = acc && !(skip && !i_last);

    always_comb begin
        o_qitem.sym  = i_symbol;
        o_qitem.last = i_last;
        if (skip) begin
            o_qitem.kind = hte_pkg::K_SKIP;
        end else if (fits) begin
            o_qitem.kind = hte_pkg::K_STORE;
        end else begin
            o_qitem.kind = hte_pkg::K_DROP;
        end
        n_cnt = r_cnt;
        if (acc) begin
            if (i_last) begin
                n_cnt = '0;
            end else if (!skip && fits) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_TEXT))
        else $error("front byte count beyond capacity");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last) |=> (r_cnt == '0))
        else $error("front byte count not cleared after final byte");

endmodule

// File: src/hte_queue.sv
module hte_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hte_pkg::t_item   i_item,
    output logic             o_full,
    input  logic             i_pop,
    output hte_pkg::t_item   o_item,
    output logic             o_empty
);

    hte_pkg::t_item                r_mem [hte_pkg::QDEPTH];
    logic [hte_pkg::QAW-1:0]       r_head;
    logic [hte_pkg::QAW-1:0]       r_tail;
    logic [hte_pkg::QCW-1:0]       r_cnt;
    logic                          wr;
    logic                          rd;

    assign o_full  = (r_cnt == hte_pkg::QCW'(hte_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_item  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_tail] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_tail <= r_tail + hte_pkg::QAW'(1);
            end
            if (rd) begin
                r_head <= r_head + hte_pkg::QAW'(1);
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + hte_pkg::QCW'(1);
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - hte_pkg::QCW'(1);
            end
        end
    end

endmodule

// File: src/hte_back.sv
module hte_back #(
    parameter int MAX_TEXT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hte_pkg::t_item    i_qitem,
    input  logic              i_qempty,
    output logic              o_qpop,
    input  logic              i_pop,
    output logic              o_empty,
    output hte_pkg::t_result  o_res
);

    localparam int AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
    localparam int CW = $clog2(MAX_TEXT + 1);
    localparam int NN = 2 * MAX_TEXT - 1;
    localparam int NW = $clog2(2 * MAX_TEXT);
    localparam int SW = hte_pkg::SYM_W;
    localparam int BW = hte_pkg::CODE_W;
    localparam int LW = hte_pkg::LEN_W;

    // Memories.
    logic [SW-1:0] mem_t  [MAX_TEXT];
    logic [AW-1:0] mem_m  [hte_pkg::SYM_NUM];
    logic [SW-1:0] mem_d  [MAX_TEXT];
    logic [CW-1:0] mem_c  [MAX_TEXT];
    logic [CW-1:0] mem_w  [NN];
    logic [NW:0]   mem_ps [NN];
    logic [BW-1:0] mem_cb [MAX_TEXT];
    logic [LW-1:0] mem_cl [MAX_TEXT];

    logic [SW-1:0] q_t;
    logic [AW-1:0] q_m;
    logic [SW-1:0] q_d;
    logic [CW-1:0] q_c;
    logic [CW-1:0] q_w;
    logic [NW:0]   q_ps;
    logic [BW-1:0] q_cb;
    logic [LW-1:0] q_cl;

    logic          t_we;
    logic [AW-1:0] t_wa, t_ra;
    logic [SW-1:0] t_wd;
    logic          m_we;
    logic [SW-1:0] m_wa, m_ra;
    logic [AW-1:0] m_wd;
    logic          d_we;
    logic [AW-1:0] d_wa, d_ra;
    logic [SW-1:0] d_wd;
    logic          c_we;
    logic [AW-1:0] c_wa, c_ra;
    logic [CW-1:0] c_wd;
    logic          w_we;
    logic [NW-1:0] w_wa, w_ra;
    logic [CW-1:0] w_wd;
    logic          ps_we;
    logic [NW-1:0] ps_wa, ps_ra;
    logic [NW:0]   ps_wd;
    logic          cb_we;
    logic [AW-1:0] cb_wa, cb_ra;
    logic [BW-1:0] cb_wd;
    logic [LW-1:0] cl_wd;

    // Control state.
    hte_pkg::t_state          r_state, n_state;
    hte_pkg::t_item           r_item, n_item;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [CW-1:0]            r_dist, n_dist;
    logic                     r_ovf, n_ovf;
    logic [hte_pkg::SYM_NUM-1:0] r_vs, n_vs;
    logic [NN-1:0]            r_alive, n_alive;
    logic                     r_ov, n_ov;
    logic                     r_pv, n_pv;

    // Working registers.
    logic [CW-1:0]            r_k, n_k;
    logic [NW-1:0]            r_j, n_j;
    logic [NW-1:0]            r_pj, n_pj;
    logic                     r_pa, n_pa;
    logic [CW-1:0]            r_ck, n_ck;
    logic [SW-1:0]            r_sk, n_sk;
    logic [CW-1:0]            r_rank, n_rank;
    logic [CW-1:0]            r_m1, n_m1, r_m2, n_m2;
    logic [NW-1:0]            r_i1, n_i1, r_i2, n_i2;
    logic                     r_h1, n_h1, r_h2, n_h2;
    logic [NW-1:0]            r_next, n_next;
    logic [CW-1:0]            r_pend, n_pend;
    logic [NW-1:0]            r_node, n_node;
    logic [BW-1:0]            r_bits, n_bits;
    logic [LW-1:0]            r_len, n_len;
    logic [AW-1:0]            r_idx, n_idx;
    hte_pkg::t_result         r_res, n_res;

    logic [NW-1:0]            root;
    logic                     last_res;

    assign o_empty  = !r_ov;
    assign o_res    = r_res;
    assign root     = r_next - NW'(1);
    assign last_res = (r_k == r_cnt - CW'(1));

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_cnt   = r_cnt;
        n_dist  = r_dist;
        n_ovf   = r_ovf;
        n_vs    = r_vs;
        n_alive = r_alive;
        n_ov    = r_ov && !i_pop;
        n_pv    = r_pv;
        n_k     = r_k;
        n_j     = r_j;
        n_pj    = r_pj;
        n_pa    = r_pa;
        n_ck    = r_ck;
        n_sk    = r_sk;
        n_rank  = r_rank;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_i1    = r_i1;
        n_i2    = r_i2;
        n_h1    = r_h1;
        n_h2    = r_h2;
        n_next  = r_next;
        n_pend  = r_pend;
        n_node  = r_node;
        n_bits  = r_bits;
        n_len   = r_len;
        n_idx   = r_idx;
        n_res   = r_res;
        o_qpop  = 1'b0;
        t_we  = 1'b0; t_wa  = '0; t_wd  = '0; t_ra  = '0;
        m_we  = 1'b0; m_wa  = '0; m_wd  = '0; m_ra  = '0;
        d_we  = 1'b0; d_wa  = '0; d_wd  = '0; d_ra  = '0;
        c_we  = 1'b0; c_wa  = '0; c_wd  = '0; c_ra  = '0;
        w_we  = 1'b0; w_wa  = '0; w_wd  = '0; w_ra  = '0;
        ps_we = 1'b0; ps_wa = '0; ps_wd = '0; ps_ra = '0;
        cb_we = 1'b0; cb_wa = '0; cb_wd = '0; cl_wd = '0; cb_ra = r_idx;

        unique case (r_state)
            hte_pkg::ST_IDLE: begin
                if (!i_qempty) begin
                    o_qpop  = 1'b1;
                    n_item  = i_qitem;
                    n_state = hte_pkg::ST_LD;
                end
            end
            hte_pkg::ST_LD: begin
                n_state = hte_pkg::ST_LEND;
                unique case (r_item.kind)
                    hte_pkg::K_STORE: begin
                        t_we  = 1'b1;
                        t_wa  = r_cnt[AW-1:0];
                        t_wd  = r_item.sym;
                        n_cnt = r_cnt + CW'(1);
                        if (r_vs[r_item.sym]) begin
                            m_ra    = r_item.sym;
                            n_state = hte_pkg::ST_LM;
                        end else begin
                            // First sighting: open a new distinct entry.
                            m_we = 1'b1;
                            m_wa = r_item.sym;
                            m_wd = r_dist[AW-1:0];
                            d_we = 1'b1;
                            d_wa = r_dist[AW-1:0];
                            d_wd = r_item.sym;
                            c_we = 1'b1;
                            c_wa = r_dist[AW-1:0];
                            c_wd = CW'(1);
                            n_vs[r_item.sym] = 1'b1;
                            n_dist = r_dist + CW'(1);
                        end
                    end
                    hte_pkg::K_DROP: begin
                        n_ovf = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            hte_pkg::ST_LM: begin
                c_ra    = q_m;
                n_idx   = q_m;
                n_state = hte_pkg::ST_LC;
            end
            hte_pkg::ST_LC: begin
                c_we    = 1'b1;
                c_wa    = r_idx;
                c_wd    = q_c + CW'(1);
                n_state = hte_pkg::ST_LEND;
            end
            hte_pkg::ST_LEND: begin
                n_state = hte_pkg::ST_IDLE;
                if (r_item.last) begin
                    if (r_cnt == '0) begin
                        n_ovf   = 1'b0;
                        n_dist  = '0;
                        n_vs    = '0;
                        n_alive = '0;
                    end else begin
                        n_k     = '0;
                        n_state = hte_pkg::ST_RK0;
                    end
                end
            end
            hte_pkg::ST_RK0: begin
                c_ra    = r_k[AW-1:0];
                d_ra    = r_k[AW-1:0];
                n_state = hte_pkg::ST_RK1;
            end
            hte_pkg::ST_RK1: begin
                n_ck    = q_c;
                n_sk    = q_d;
                n_j     = '0;
                n_pv    = 1'b0;
                n_rank  = '0;
                n_state = hte_pkg::ST_RS;
            end
            hte_pkg::ST_RS: begin
                // Sorted position: smaller counts, plus equal counts seen earlier.
                if (r_pv) begin
                    if ((q_c < r_ck) || ((q_c == r_ck) && (r_pj < NW'(r_k)))) begin
                        n_rank = r_rank + CW'(1);
                    end
                end
                if (r_j < NW'(r_dist)) begin
                    c_ra = r_j[AW-1:0];
                    n_pv = 1'b1;
                    n_pj = r_j;
                    n_j  = r_j + NW'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = hte_pkg::ST_RW;
                    end
                end
            end
            hte_pkg::ST_RW: begin
                w_we = 1'b1;
                w_wa = NW'(r_rank);
                w_wd = r_ck;
                m_we = 1'b1;
                m_wa = r_sk;
                m_wd = r_rank[AW-1:0];
                n_alive[NW'(r_rank)] = 1'b1;
                if (r_k == r_dist - CW'(1)) begin
                    n_next  = NW'(r_dist);
                    n_pend  = r_dist;
                    n_state = hte_pkg::ST_MG0;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = hte_pkg::ST_RK0;
                end
            end
            hte_pkg::ST_MG0: begin
                if (r_pend <= CW'(1)) begin
                    n_k     = '0;
                    n_state = hte_pkg::ST_WK0;
                end else begin
                    n_j     = '0;
                    n_pv    = 1'b0;
                    n_h1    = 1'b0;
                    n_h2    = 1'b0;
                    n_state = hte_pkg::ST_MS;
                end
            end
            hte_pkg::ST_MS: begin
                // Pending nodes are the live ones in index order; strict compares
                // keep the earliest of equal weights.
                if (r_pv && r_pa) begin
                    if (!r_h1 || (q_w < r_m1)) begin
                        n_m2 = r_m1;
                        n_i2 = r_i1;
                        n_h2 = r_h1;
                        n_m1 = q_w;
                        n_i1 = r_pj;
                        n_h1 = 1'b1;
                    end else if (!r_h2 || (q_w < r_m2)) begin
                        n_m2 = q_w;
                        n_i2 = r_pj;
                        n_h2 = 1'b1;
                    end
                end
                if (r_j < r_next) begin
                    w_ra = r_j;
                    n_pa = r_alive[r_j];
                    n_pv = 1'b1;
                    n_pj = r_j;
                    n_j  = r_j + NW'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = hte_pkg::ST_MW1;
                    end
                end
            end
            hte_pkg::ST_MW1: begin
                w_we  = 1'b1;
                w_wa  = r_next;
                w_wd  = r_m1 + r_m2;
                ps_we = 1'b1;
                ps_wa = r_i1;
                ps_wd = {1'b0, r_next};
                n_alive[r_i1]   = 1'b0;
                n_alive[r_i2]   = 1'b0;
                n_alive[r_next] = 1'b1;
                n_state = hte_pkg::ST_MW2;
            end
            hte_pkg::ST_MW2: begin
                ps_we   = 1'b1;
                ps_wa   = r_i2;
                ps_wd   = {1'b1, r_next};
                n_next  = r_next + NW'(1);
                n_pend  = r_pend - CW'(1);
                n_state = hte_pkg::ST_MG0;
            end
            hte_pkg::ST_WK0: begin
                n_node  = NW'(r_k);
                n_bits  = '0;
                n_len   = '0;
                n_state = hte_pkg::ST_WK1;
            end
            hte_pkg::ST_WK1: begin
                if ((r_node == root) || (r_len == hte_pkg::LEN_MAX)) begin
                    cb_we = 1'b1;
                    cb_wa = r_k[AW-1:0];
                    cb_wd = r_bits;
                    // A lone distinct symbol still gets a one-bit code.
                    cl_wd = (r_dist == CW'(1)) ? LW'(1) : r_len;
                    if (r_k == r_dist - CW'(1)) begin
                        n_k     = '0;
                        n_state = hte_pkg::ST_E0;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = hte_pkg::ST_WK0;
                    end
                end else begin
                    ps_ra   = r_node;
                    n_state = hte_pkg::ST_WK2;
                end
            end
            hte_pkg::ST_WK2: begin
                n_bits[r_len] = q_ps[NW];
                n_len   = r_len + LW'(1);
                n_node  = q_ps[NW-1:0];
                n_state = hte_pkg::ST_WK1;
            end
            hte_pkg::ST_E0: begin
                t_ra    = r_k[AW-1:0];
                n_state = hte_pkg::ST_E1;
            end
            hte_pkg::ST_E1: begin
                n_sk    = q_t;
                m_ra    = q_t;
                n_state = hte_pkg::ST_E2;
            end
            hte_pkg::ST_E2: begin
                cb_ra   = q_m;
                n_idx   = q_m;
                n_state = hte_pkg::ST_E3;
            end
            hte_pkg::ST_E3: begin
                if (!r_ov || i_pop) begin
                    n_ov              = 1'b1;
                    n_res.sym         = r_sk;
                    n_res.code_word   = q_cb;
                    n_res.code_length = q_cl;
                    n_res.overflowed  = r_ovf;
                    n_res.end_of_run  = last_res;
                    if (last_res) begin
                        n_cnt   = '0;
                        n_dist  = '0;
                        n_ovf   = 1'b0;
                        n_vs    = '0;
                        n_alive = '0;
                        n_state = hte_pkg::ST_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = hte_pkg::ST_E0;
                    end
                end
            end
            default: begin
                n_state = hte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hte_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_dist  <= '0;
            r_ovf   <= 1'b0;
            r_vs    <= '0;
            r_alive <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dist  <= n_dist;
            r_ovf   <= n_ovf;
            r_vs    <= n_vs;
            r_alive <= n_alive;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_k    <= n_k;
        r_j    <= n_j;
        r_pj   <= n_pj;
        r_pa   <= n_pa;
        r_ck   <= n_ck;
        r_sk   <= n_sk;
        r_rank <= n_rank;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_i1   <= n_i1;
        r_i2   <= n_i2;
        r_h1   <= n_h1;
        r_h2   <= n_h2;
        r_next <= n_next;
        r_pend <= n_pend;
        r_node <= n_node;
        r_bits <= n_bits;
        r_len  <= n_len;
        r_idx  <= n_idx;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            mem_t[t_wa] <= t_wd;
        end
        q_t <= mem_t[t_ra];
        if (m_we) begin
            mem_m[m_wa] <= m_wd;
        end
        q_m <= mem_m[m_ra];
        if (d_we) begin
            mem_d[d_wa] <= d_wd;
        end
        q_d <= mem_d[d_ra];
        if (c_we) begin
            mem_c[c_wa] <= c_wd;
        end
        q_c <= mem_c[c_ra];
        if (w_we) begin
            mem_w[w_wa] <= w_wd;
        end
        q_w <= mem_w[w_ra];
        if (ps_we) begin
            mem_ps[ps_wa] <= ps_wd;
        end
        q_ps <= mem_ps[ps_ra];
        if (cb_we) begin
            mem_cb[cb_wa] <= cb_wd;
            mem_cl[cb_wa] <= cl_wd;
        end
        q_cb <= mem_cb[cb_ra];
        q_cl <= mem_cl[cb_ra];
    end

    a_merge_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hte_pkg::ST_MW1) |-> (r_h1 && r_h2 && (r_i1 != r_i2)))
        else $error("merge picked the same node twice");

    a_dist_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= r_cnt)
        else $error("more distinct symbols than stored bytes");

    a_store_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == hte_pkg::ST_LD) && (r_item.kind == hte_pkg::K_STORE))
            |-> (r_cnt < CW'(MAX_TEXT)))
        else $error("store word arrived with the text store full");

endmodule

// File: src/huffman_text_encoder_unit.sv
// Static Huffman text encoder. Bytes are pushed one word at a time; byte 8 is
// ignored and bytes past MAX_TEXT are dropped and flagged in overflowed. The
// word with last set closes the text: the block then sorts the distinct symbols,
// counted while loading, stably by count, builds the tree and pops out one code
// word per stored byte in text order, root bit at position code_length-1. A small
// queue separates the input side from the engine, so push keeps being taken while
// the engine is busy until that queue fills. A repeated symbol costs extra load
// steps, a symbol map read and then a count read, before its count is written.
// After the last byte the engine ranks the distinct symbols, merges the two
// lightest pending nodes until one remains, and walks each symbol up to the root
// for its code. Each code word is then fetched through three chained memory reads
// (text store, symbol map, code memory), waiting while an earlier word is not
// popped. An empty text produces no words.
module huffman_text_encoder_unit #(
    parameter int MAX_TEXT = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [hte_pkg::SYM_W-1:0]    i_symbol,
    input  logic                         i_last,
    output logic                         empty,
    input  logic                         pop,
    output logic [hte_pkg::SYM_W-1:0]    o_out_symbol,
    output logic [hte_pkg::CODE_W-1:0]   o_code_word,
    output logic [hte_pkg::LEN_W-1:0]    o_code_length,
    output logic                         o_overflowed,
    output logic                         o_end_of_run
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    hte_pkg::t_item    q_in;
    hte_pkg::t_item    q_out;
    hte_pkg::t_result  res;

    hte_front #(
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_symbol (i_symbol),
        .i_last   (i_last),
        .i_qfull  (q_full),
        .o_full   (full),
        .o_qpush  (q_push),
        .o_qitem  (q_in)
    );

    hte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out),
        .o_empty (q_empty)
    );

    hte_back #(
        .MAX_TEXT (MAX_TEXT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qitem  (q_out),
        .i_qempty (q_empty),
        .o_qpop   (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_res    (res)
    );

    assign o_out_symbol  = res.sym;
    assign o_code_word   = res.code_word;
    assign o_code_length = res.code_length;
    assign o_overflowed  = res.overflowed;
    assign o_end_of_run  = res.end_of_run;

endmodule

// File: test/huffman_text_encoder_unit_tb.sv
`timescale 1ns / 100ps

module huffman_text_encoder_unit_tb;

    localparam int TEXT_CAP = 64;
    localparam int NODE_CAP = 2 * TEXT_CAP;
    localparam int TAIL_CYCLES = 1000;
    localparam int HOLD_CYCLES = 600;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [hte_pkg::SYM_W-1:0]      i_symbol;
    logic                           i_last;
    logic                           empty;
    logic                           pop;
    logic [hte_pkg::SYM_W-1:0]      o_out_symbol;
    logic [hte_pkg::CODE_W-1:0]     o_code_word;
    logic [hte_pkg::LEN_W-1:0]      o_code_length;
    logic                           o_overflowed;
    logic                           o_end_of_run;

    huffman_text_encoder_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_symbol      (i_symbol),
        .i_last        (i_last),
        .empty         (empty),
        .pop           (pop),
        .o_out_symbol  (o_out_symbol),
        .o_code_word   (o_code_word),
        .o_code_length (o_code_length),
        .o_overflowed  (o_overflowed),
        .o_end_of_run  (o_end_of_run)
    );

    typedef struct {
        logic [hte_pkg::SYM_W-1:0]  sym;
        logic                       last;
        bit                         typed;
        logic [hte_pkg::CODE_W-1:0] code_word;
        logic [hte_pkg::LEN_W-1:0]  code_length;
        logic                       overflowed;
    } t_row;

    // Directed texts: skipped-only text, single symbols, small skewed texts, a tie.
    t_row stim_rows [] = '{
        '{hte_pkg::SKIP_BYTE, 1'b1, 1'b0, '0, '0, 1'b0},
        '{8'h00, 1'b1, 1'b1, '0, 6'd1, 1'b0},
        '{8'hFF, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'hFF, 1'b0, 1'b0, '0, '0, 1'b0},
        '{hte_pkg::SKIP_BYTE, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'hFF, 1'b1, 1'b1, '0, 6'd1, 1'b0},
        '{8'h01, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h02, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h03, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h01, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h01, 1'b1, 1'b0, '0, '0, 1'b0},
        '{8'hAA, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h55, 1'b1, 1'b0, '0, '0, 1'b0},
        '{8'h80, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h80, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h23, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h7F, 1'b0, 1'b0, '0, '0, 1'b0},
        '{8'h80, 1'b1, 1'b0, '0, '0, 1'b0}
    };

    // Predictor state: text of the current run and its overflow status.
    logic [hte_pkg::SYM_W-1:0] run_text [$];
    bit                        run_dropped;
    hte_pkg::t_result          code_queue [$];

    int send_idle_pct;
    int recv_idle_pct;
    int phase;
    bit hold_done;
    bit stim_done;
    int err_cnt;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Builds the Huffman codes for the finished text and queues one word per byte.
    task automatic encode_run(input bit typed, input hte_pkg::t_result typed_val);
        logic [hte_pkg::SYM_W-1:0] dsym [$];
        int cnt [TEXT_CAP];
        int ord [TEXT_CAP];
        int wt [NODE_CAP];
        int par [NODE_CAP];
        int sd [NODE_CAP];
        logic [hte_pkg::CODE_W-1:0] cbits [TEXT_CAP];
        int clen [TEXT_CAP];
        int pend [$];
        int d, j, k, nxt, root, a, b, node, len, best, idx;
        logic [hte_pkg::CODE_W-1:0] bits;
        hte_pkg::t_result r;
        d = 0;
        foreach (run_text[i]) begin
            idx = d;
            for (j = 0; j < d; j++) begin
                if (dsym[j] == run_text[i] && idx == d) idx = j;
            end
            if (idx == d) begin
                dsym.push_back(run_text[i]);
                cnt[d] = 0;
                d++;
            end
            cnt[idx]++;
        end
        for (int i = 0; i < d; i++) begin
            j = i;
            while (j > 0 && cnt[ord[j-1]] > cnt[i]) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = i;
        end
        for (int i = 0; i < d; i++) begin
            wt[i] = cnt[ord[i]];
            pend.push_back(i);
        end
        nxt = d;
        while (pend.size() > 1 && nxt < NODE_CAP) begin
            for (int t = 0; t < 2; t++) begin
                best = 0;
                for (j = 1; j < pend.size(); j++) begin
                    if (wt[pend[j]] < wt[pend[best]]) best = j;
                end
                if (t == 0) a = pend[best];
                else b = pend[best];
                pend.delete(best);
            end
            wt[nxt] = (wt[a] + wt[b]) & 8'h7F;
            par[a] = nxt;
            sd[a] = 0;
            par[b] = nxt;
            sd[b] = 1;
            pend.push_back(nxt);
            nxt++;
        end
        root = nxt - 1;
        for (k = 0; k < d; k++) begin
            bits = '0;
            len = 0;
            node = k;
            if (d == 1) begin
                len = 1;
            end else begin
                while (node != root && len < 63) begin
                    if (sd[node] != 0) bits[len] = 1'b1;
                    len++;
                    node = par[node];
                end
            end
            cbits[ord[k]] = bits;
            clen[ord[k]] = len;
        end
        foreach (run_text[i]) begin
            idx = 0;
            for (j = d - 1; j >= 0; j--) begin
                if (dsym[j] == run_text[i]) idx = j;
            end
            r.sym = run_text[i];
            r.code_word = cbits[idx];
            r.code_length = hte_pkg::LEN_W'(clen[idx]);
            r.overflowed = run_dropped;
            r.end_of_run = (i == run_text.size() - 1);
            if (typed) begin
                r.code_word = typed_val.code_word;
                r.code_length = typed_val.code_length;
                r.overflowed = typed_val.overflowed;
            end
            code_queue.push_back(r);
        end
    endtask

    task automatic accept_byte(input logic [hte_pkg::SYM_W-1:0] sym, input logic last,
                               input bit typed, input hte_pkg::t_result typed_val);
        if (sym != hte_pkg::SKIP_BYTE) begin
            if (run_text.size() < TEXT_CAP) run_text.push_back(sym);
            else run_dropped = 1'b1;
        end
        if (last) begin
            if (run_text.size() != 0) encode_run(typed, typed_val);
            run_text.delete();
            run_dropped = 1'b0;
        end
    endtask

    task automatic send_byte(input logic [hte_pkg::SYM_W-1:0] sym, input logic last,
                             input bit typed = 1'b0,
                             input hte_pkg::t_result typed_val = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_symbol <= sym;
        i_last <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        accept_byte(sym, last, typed, typed_val);
    endtask

    task automatic send_random_text();
        int n, mode;
        logic [hte_pkg::SYM_W-1:0] base, s;
        n = $urandom_range(3, 6);
        mode = $urandom_range(2);
        base = hte_pkg::SYM_W'($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) s = hte_pkg::SKIP_BYTE;
            else if (mode == 0) s = base + hte_pkg::SYM_W'($urandom_range(3));
            else if (mode == 1) s = base + hte_pkg::SYM_W'($urandom_range(12));
            else s = hte_pkg::SYM_W'($urandom);
            send_byte(s, i == n - 1);
        end
    endtask

    initial begin
        hte_pkg::t_result tv;
        push = 1'b0;
        pop = 1'b0;
        i_symbol = '0;
        i_last = 1'b0;
        i_rst_n = 1'b0;
        run_dropped = 1'b0;
        send_idle_pct = 37;
        recv_idle_pct = 78;
        phase = 0;
        hold_done = 1'b0;
        stim_done = 1'b0;
        err_cnt = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            tv = '0;
            tv.code_word = stim_rows[i].code_word;
            tv.code_length = stim_rows[i].code_length;
            tv.overflowed = stim_rows[i].overflowed;
            send_byte(stim_rows[i].sym, stim_rows[i].last, stim_rows[i].typed, tv);
        end

        // Sixty-four distinct symbols, then a closing byte that is itself dropped.
        for (int i = 0; i < 65; i++) send_byte(8'd100 + i[7:0], i == 64);

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 78 : 0;
            recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 37 : 0;
            for (int t = 0; t < 3; t++) send_random_text();
            // A text made only of ignored bytes produces no word.
            if (phase == 1) begin
                send_byte(hte_pkg::SKIP_BYTE, 1'b0);
                send_byte(hte_pkg::SKIP_BYTE, 1'b1);
            end
        end
        push <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side; the long hold at the start of the last phase backs up the block.
    initial begin
        int hold_cnt;
        hte_pkg::t_result got, exp_r;
        @(posedge i_rst_n);
        forever begin
            if (phase == 2 && !hold_done) begin
                hold_cnt = 0;
                pop <= 1'b0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                hold_done = 1'b1;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge i_clk);
            if (pop && !empty) begin
                got.sym = o_out_symbol;
                got.code_word = o_code_word;
                got.code_length = o_code_length;
                got.overflowed = o_overflowed;
                got.end_of_run = o_end_of_run;
                if (code_queue.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected word: sym %h code %h len %0d", got.sym,
                                 got.code_word, got.code_length);
                end else begin
                    exp_r = code_queue.pop_front();
                    if (got !== exp_r) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display({"mismatch: exp sym %h code %h len %0d ovf %b end %b",
                                      " / got sym %h code %h len %0d ovf %b end %b"},
                                     exp_r.sym, exp_r.code_word, exp_r.code_length,
                                     exp_r.overflowed, exp_r.end_of_run, got.sym,
                                     got.code_word, got.code_length, got.overflowed,
                                     got.end_of_run);
                    end
                end
            end
        end
    end

    initial begin
        wait (stim_done);
        while (code_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && code_queue.size() == 0) begin
            $display("huffman_text_encoder_unit test passed");
        end else begin
            $display("huffman_text_encoder_unit test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("huffman_text_encoder_unit test failed");
        $finish;
    end

endmodule
